// File: rtl/sssp_pkg.sv
// Package for the shortest path block: sizes, word types and cell control.
// No dependencies.
`timescale 1ns / 1ps
package sssp_pkg;
    localparam int NODES       = 16;
    localparam int WEIGHT_BITS = 16;
    localparam int NODE_BITS   = 4;
    localparam int IDX_BITS    = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int DIST_BITS   = WEIGHT_BITS + IDX_BITS + 1;
    localparam int ADDR_BITS   = 2 * IDX_BITS;
    localparam int MAT_DEPTH   = NODES * NODES;
    localparam int OUT_DIST_BITS = 20;
    localparam logic [OUT_DIST_BITS-1:0] DIST_SAT = '1;

    typedef struct packed {
        logic [3:0]  from_node;
        logic [3:0]  to_node;
        logic [15:0] weight;
        logic        last_edge;
    } t_in_word;

    typedef struct packed {
        logic [3:0]  node;
        logic [19:0] distance;
        logic        reachable;
        logic [3:0]  predecessor;
        logic        has_predecessor;
        logic        last_result;
    } t_out_word;

    typedef enum logic [2:0] {
        ST_LOAD, ST_INIT, ST_SELECT, ST_RELAX, ST_EMIT, ST_CLEAR
    } t_state;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic                 init;      // clear done/reached, mark start
        logic [IDX_BITS-1:0]  start;
        logic                 start_ok;
        logic                 mark;      // set done on the selected node
        logic [IDX_BITS-1:0]  sel;
        logic                 relax;     // relax one edge
        logic [IDX_BITS-1:0]  dst;
        logic [DIST_BITS-1:0] cand;
        logic                 wnz;
        logic                 shift;     // rotate result chain one place
    } t_cell_ctrl;
endpackage

// File: rtl/sssp_ram.sv
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module sssp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: rtl/sssp_cell.sv
// One node cell: holds distance, predecessor, reached and done for its node,
// and registers the running minimum and result data for its neighbor. Uses sssp_pkg.
`timescale 1ns / 1ps
module sssp_cell (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [sssp_pkg::IDX_BITS-1:0]      i_id,
    input  sssp_pkg::t_cell_ctrl               i_ctrl,
    input  logic                               i_min_vld,
    input  logic [sssp_pkg::DIST_BITS-1:0]     i_min_dist,
    input  logic [sssp_pkg::IDX_BITS-1:0]      i_min_idx,
    output logic                               o_min_vld,
    output logic [sssp_pkg::DIST_BITS-1:0]     o_min_dist,
    output logic [sssp_pkg::IDX_BITS-1:0]      o_min_idx,
    input  logic                               i_res_reach,
    input  logic [sssp_pkg::DIST_BITS-1:0]     i_res_dist,
    input  logic [sssp_pkg::IDX_BITS-1:0]      i_res_pred,
    output logic                               o_res_reach,
    output logic [sssp_pkg::DIST_BITS-1:0]     o_res_dist,
    output logic [sssp_pkg::IDX_BITS-1:0]      o_res_pred
);
    import sssp_pkg::*;
    logic                 r_reached, r_done;
    logic [DIST_BITS-1:0] r_dist;
    logic [IDX_BITS-1:0]  r_pred;
    logic                 w_mine;
    logic                 w_min_vld;
    logic [DIST_BITS-1:0] w_min_dist;
    logic [IDX_BITS-1:0]  w_min_idx;
    logic                 r_min_vld;
    logic [DIST_BITS-1:0] r_min_dist;
    logic [IDX_BITS-1:0]  r_min_idx;

    // Candidate for the minimum; strict less keeps the lower index on ties
    // since the chain runs from node 0 upward.
    assign w_mine = r_reached && !r_done;
    always_comb begin
        w_min_vld  = i_min_vld;
        w_min_dist = i_min_dist;
        w_min_idx  = i_min_idx;
        if (w_mine && (!i_min_vld || r_dist < i_min_dist)) begin
            w_min_vld  = 1'b1;
            w_min_dist = r_dist;
            w_min_idx  = i_id;
        end
    end

    // The running minimum moves one cell per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_vld <= 1'b0;
        end else begin
            r_min_vld <= w_min_vld;
        end
        r_min_dist <= w_min_dist;
        r_min_idx  <= w_min_idx;
    end
    assign o_min_vld   = r_min_vld;
    assign o_min_dist  = r_min_dist;
    assign o_min_idx   = r_min_idx;
    assign o_res_reach = r_reached;
    assign o_res_dist  = r_dist;
    assign o_res_pred  = r_pred;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reached <= 1'b0;
            r_done    <= 1'b0;
        end else if (i_ctrl.init) begin
            r_done    <= 1'b0;
            r_reached <= i_ctrl.start_ok && (i_ctrl.start == i_id);
            r_dist    <= '0;
        end else if (i_ctrl.mark) begin
            if (i_ctrl.sel == i_id) begin
                r_done <= 1'b1;
            end
        end else if (i_ctrl.relax) begin
            if (i_ctrl.dst == i_id && i_ctrl.wnz && !r_done &&
                (!r_reached || i_ctrl.cand < r_dist)) begin
                r_reached <= 1'b1;
                r_dist    <= i_ctrl.cand;
                r_pred    <= i_ctrl.sel;
            end
        end else if (i_ctrl.shift) begin
            r_reached <= i_res_reach;
            r_dist    <= i_res_dist;
            r_pred    <= i_res_pred;
        end
    end
endmodule

// File: rtl/single_source_shortest_path_top.sv
// Top level of the shortest path block: matrix RAM, row of node cells and
// the sequencer. Uses sssp_pkg, sssp_ram and sssp_cell.
`timescale 1ns / 1ps
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------
//  in      | input     | i_in_valid/o_in_stall | i_in_word
//  out     | output    | o_out_valid/i_out_stall | o_out_word
//  cfg     | input     | APB                  | start_node at 0x0
//
// An in-range edge word without last_edge is stored and the next word can
// follow immediately. A last edge starts the search: per extracted node, the
// running minimum ripples through the registered cell chain, then the node's
// matrix row is walked (one RAM read per cycle). A final pick that finds no
// candidate ends the search, and an out-of-range start node skips it. Results
// then leave one per cycle while the output does not stall, as the cell chain
// rotates, and a pass over every address clears the matrix RAM.
// Reset is synchronous and active low; the matrix RAM is not valid-tracked,
// so after reset the block first runs the clearing pass before taking words.
// A stalled output word holds; the result rotation waits while the output stalls.
module single_source_shortest_path_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  sssp_pkg::t_in_word   i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output sssp_pkg::t_out_word  o_out_word,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [1:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import sssp_pkg::*;

    t_state r_state, n_state;
    logic [3:0]           r_start;
    logic [ADDR_BITS:0]   r_cnt, n_cnt;     // sweep and pick counter, one extra bit
    logic [IDX_BITS:0]    r_col;            // column walk, one extra for latency
    logic [IDX_BITS-1:0]  r_sel;
    logic [DIST_BITS-1:0] r_sel_dist;
    logic [IDX_BITS:0]    r_emit;
    logic                 r_out_valid;
    t_out_word            r_out_word;

    // Configuration port.
    assign pready = 1'b1;
    assign prdata = {28'd0, r_start};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
        end else if (psel && penable && pwrite && paddr == 2'd0) begin
            r_start <= pwdata[3:0];
        end
    end

    // Matrix RAM: written by loads and the clearing pass, read by the row walk.
    logic                   w_we;
    logic [ADDR_BITS-1:0]   w_waddr, w_raddr;
    logic [WEIGHT_BITS-1:0] w_wdata, w_rdata;
    logic                   w_in_ok, w_acc;

    assign w_in_ok = (i_in_word.from_node < 5'(NODES)) && (i_in_word.to_node < 5'(NODES));
    assign w_acc   = i_in_valid && !o_in_stall;
    assign w_we    = (w_acc && w_in_ok) || (r_state == ST_CLEAR);
    assign w_waddr = (r_state == ST_CLEAR) ? r_cnt[ADDR_BITS-1:0]
                   : {i_in_word.from_node[IDX_BITS-1:0], i_in_word.to_node[IDX_BITS-1:0]};
    assign w_wdata = (r_state == ST_CLEAR) ? '0 : WEIGHT_BITS'(i_in_word.weight);
    assign w_raddr = {r_sel, r_col[IDX_BITS-1:0]};

    sssp_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(MAT_DEPTH)) u_mat (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(w_raddr), .o_rdata(w_rdata)
    );

    // Cell chain.
    t_cell_ctrl            w_ctrl;
    logic [NODES:0]                 c_min_vld;
    logic [DIST_BITS-1:0]           c_min_dist [NODES+1];
    logic [IDX_BITS-1:0]            c_min_idx  [NODES+1];
    logic [NODES:0]                 c_reach;
    logic [DIST_BITS-1:0]           c_dist [NODES+1];
    logic [IDX_BITS-1:0]            c_pred [NODES+1];

    assign c_min_vld[0]  = 1'b0;
    assign c_min_dist[0] = '0;
    assign c_min_idx[0]  = '0;
    // Results rotate toward cell 0; the word read leaves cell 0.
    assign c_reach[NODES] = c_reach[0];
    assign c_dist[NODES]  = c_dist[0];
    assign c_pred[NODES]  = c_pred[0];

    for (genvar g = 0; g < NODES; g++) begin : g_cell
        sssp_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_id(IDX_BITS'(g)), .i_ctrl(w_ctrl),
            .i_min_vld(c_min_vld[g]), .i_min_dist(c_min_dist[g]),
            .i_min_idx(c_min_idx[g]),
            .o_min_vld(c_min_vld[g+1]), .o_min_dist(c_min_dist[g+1]),
            .o_min_idx(c_min_idx[g+1]),
            .i_res_reach(c_reach[g+1]), .i_res_dist(c_dist[g+1]),
            .i_res_pred(c_pred[g+1]),
            .o_res_reach(c_reach[g]), .o_res_dist(c_dist[g]), .o_res_pred(c_pred[g])
        );
    end

    // The row walk addresses column r_col; its data arrives in the cycle after.
    logic [IDX_BITS:0]    r_col_d;
    logic                 r_rd_vld;
    logic                 w_start_ok;
    logic                 w_out_free;
    logic                 w_sel_ready;
    // Mark uses the index of the minimum at the end of the chain.
    logic [IDX_BITS-1:0]  w_mark_sel;
    assign w_start_ok  = r_start < 5'(NODES);
    assign w_out_free  = !r_out_valid || !i_out_stall;
    // The minimum has passed every cell once the pick counter reaches NODES.
    assign w_sel_ready = (r_cnt == (ADDR_BITS+1)'(NODES));
    assign w_mark_sel  = c_min_idx[NODES];

    always_comb begin
        w_ctrl          = '0;
        w_ctrl.start    = r_start[IDX_BITS-1:0];
        w_ctrl.start_ok = w_start_ok;
        w_ctrl.sel      = (r_state == ST_SELECT) ? w_mark_sel : r_sel;
        w_ctrl.dst      = r_col_d[IDX_BITS-1:0];
        w_ctrl.cand     = r_sel_dist + DIST_BITS'(w_rdata);
        w_ctrl.wnz      = (w_rdata != '0);
        case (r_state)
            ST_INIT:   w_ctrl.init  = 1'b1;
            ST_SELECT: w_ctrl.mark  = w_sel_ready && c_min_vld[NODES];
            ST_RELAX:  w_ctrl.relax = r_rd_vld;
            ST_EMIT:   w_ctrl.shift = w_out_free;
            default:   w_ctrl.init  = 1'b0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            ST_LOAD:   if (w_acc && i_in_word.last_edge) n_state = ST_INIT;
            ST_INIT: begin
                n_state = w_start_ok ? ST_SELECT : ST_EMIT;
                n_cnt   = '0;
            end
            ST_SELECT: begin
                if (w_sel_ready) begin
                    n_state = c_min_vld[NODES] ? ST_RELAX : ST_EMIT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_RELAX: begin
                if (r_rd_vld && r_col_d == (IDX_BITS+1)'(NODES-1)) begin
                    n_state = ST_SELECT;
                    n_cnt   = '0;
                end
            end
            ST_EMIT: begin
                if (w_out_free && r_emit == (IDX_BITS+1)'(NODES-1)) begin
                    n_state = ST_CLEAR;
                    n_cnt   = '0;
                end
            end
            ST_CLEAR: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == (ADDR_BITS+1)'(MAT_DEPTH-1)) n_state = ST_LOAD;
            end
            default:   n_state = ST_LOAD;
        endcase
    end

    assign o_in_stall = (r_state != ST_LOAD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_cnt       <= '0;
            r_col       <= '0;
            r_col_d     <= '0;
            r_rd_vld    <= 1'b0;
            r_emit      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (r_state == ST_SELECT) begin
                r_sel      <= w_mark_sel;
                r_sel_dist <= c_min_dist[NODES];
                r_col      <= '0;
                r_rd_vld   <= 1'b0;
            end else if (r_state == ST_RELAX) begin
                r_rd_vld <= r_col < (IDX_BITS+1)'(NODES);
                r_col_d  <= r_col;
                if (r_col < (IDX_BITS+1)'(NODES)) r_col <= r_col + 1'b1;
            end
            if (r_state == ST_INIT) r_emit <= '0;
            if (r_state == ST_EMIT && w_out_free) begin
                r_out_valid <= 1'b1;
                r_emit      <= r_emit + 1'b1;
            end else if (o_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result word from cell 0 as the chain rotates.
    logic                     w_hp;
    logic [DIST_BITS-1:0]     w_d;
    assign w_hp = c_reach[0] && (5'(r_emit) != 5'(r_start));
    assign w_d  = c_reach[0] ? c_dist[0] : '0;
    always_ff @(posedge i_clk) begin
        if (r_state == ST_EMIT && w_out_free) begin
            r_out_word.node      <= 4'(r_emit);
            r_out_word.distance  <= (w_d > DIST_BITS'(DIST_SAT)) ? DIST_SAT
                                                                : OUT_DIST_BITS'(w_d);
            r_out_word.reachable <= c_reach[0];
            r_out_word.predecessor     <= w_hp ? 4'(c_pred[0]) : 4'd0;
            r_out_word.has_predecessor <= w_hp;
            r_out_word.last_result     <= (r_emit == (IDX_BITS+1)'(NODES-1));
        end
    end
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;
endmodule
